### rtl/core/serial_date_time_converter_macros.svh
// ----------------------------------------------------------------------------
// serial_date_time_converter_macros
// assertion macros used by the converter top level
// ----------------------------------------------------------------------------
`ifndef SERIAL_DATE_TIME_CONVERTER_MACROS_SVH
`define SERIAL_DATE_TIME_CONVERTER_MACROS_SVH

`ifndef SYNTH

`define SDTC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdtc assertion failed");

`define SDTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdtc assertion failed");

`else

`define SDTC_ASSERT_IMPL(label, ante, cons)

`define SDTC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/sdtc_pkg.sv
// ----------------------------------------------------------------------------
// sdtc_pkg
// shared types, constants and month tables of the date and time converter
// ----------------------------------------------------------------------------
`default_nettype none

package sdtc_pkg;

    localparam int PIPE_DEPTH = 8;
    localparam int ENC_LINE   = PIPE_DEPTH - 2;
    localparam int DATA_W     = 104;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam int MONTHS      = 12;
    localparam int FEBRUARY    = 2;
    localparam int MAX_YEAR    = 9999;
    localparam int DAY_BASE    = 693594;
    localparam int SHIFT_BASE  = 693900;
    localparam int MAX_SERIAL  = 2958465;
    localparam int MAX_DAY_MS  = 86399999;
    localparam int QUAD_CENT   = 146097;
    localparam int QUAD_YEAR   = 1461;
    localparam int FIVE_MONTH  = 153;
    localparam int YEAR_DAYS   = 365;
    localparam int CENTURY     = 100;
    localparam int MONTH_WRAP  = 10;
    localparam int MARCH_SHIFT = 3;
    localparam int JAN_SHIFT   = 9;

    localparam int MS_PER_HOUR   = 3600000;
    localparam int MS_PER_MIN    = 60000;
    localparam int MS_PER_SEC    = 1000;
    localparam int MIN_PER_HOUR  = 60;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;
    localparam int MAX_MILLI     = 999;

    // floor reciprocals, quotient is exact or one low
    localparam int CENT_MUL = 5243;
    localparam int CENT_SH  = 19;
    localparam int QC_MUL   = 114;
    localparam int QC_SH    = 24;
    localparam int QY_MUL   = 179;
    localparam int QY_SH    = 18;
    localparam int FM_MUL   = 13;
    localparam int FM_SH    = 11;
    localparam int FIVE_MUL = 205;
    localparam int FIVE_SH  = 10;
    localparam int MIN_MUL  = 2236;
    localparam int MIN_SH   = 27;
    localparam int HR_MUL   = 34;
    localparam int HR_SH    = 11;
    localparam int SEC_MUL  = 65;
    localparam int SEC_SH   = 16;

    typedef struct packed {
        logic              action;
        logic [13:0]       year_in;
        logic [3:0]        month_in;
        logic [4:0]        day_in;
        logic [5:0]        hour_in;
        logic [5:0]        minute_in;
        logic [5:0]        second_in;
        logic [9:0]        milli_in;
        logic signed [22:0] serial_day_in;
        logic [26:0]       day_ms_in;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [22:0] serial_day;
        logic [26:0]        day_ms;
    } enc_res_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
    } dec_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        unique case (m)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // days before the first of the month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sdtc_enc.sv
// ----------------------------------------------------------------------------
// sdtc_enc
// calendar date and time to serial day and milliseconds, delay matched
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_enc (
    input  logic               clk,
    input  logic               en,
    input  sdtc_pkg::in_item_t item,
    output sdtc_pkg::enc_res_t res
);
    import sdtc_pkg::*;

    typedef struct packed {
        logic        act;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] yb;
        logic [7:0]  cent_y;
        logic [7:0]  cent_yb;
        logic [4:0]  mlen;
        logic [8:0]  cum;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
    } e1_t;

    typedef struct packed {
        logic        ok;
        logic [22:0] yterm;
        logic [7:0]  cterm;
        logic [8:0]  doy;
        logic [26:0] ph;
        logic [26:0] pm;
        logic [26:0] ps;
        logic [9:0]  milli;
    } e2_t;

    e1_t      e1_reg, e1_next;
    e2_t      e2_reg, e2_next;
    enc_res_t line_reg [ENC_LINE];
    enc_res_t line_next;

    logic        leap;
    logic [4:0]  dim;
    logic [24:0] days;
    logic [26:0] tms;

    always_comb
    begin
        e1_next.act     = item.action;
        e1_next.year    = item.year_in;
        e1_next.month   = item.month_in;
        e1_next.day     = item.day_in;
        e1_next.yb      = item.year_in - 14'd1;
        e1_next.cent_y  = 8'((27'(item.year_in) * 27'(CENT_MUL)) >> CENT_SH);
        e1_next.cent_yb = 8'((27'(e1_next.yb) * 27'(CENT_MUL)) >> CENT_SH);
        e1_next.mlen    = month_len(item.month_in);
        e1_next.cum     = days_before(item.month_in);
        e1_next.hour    = (item.hour_in > 6'(MAX_HOUR)) ? 5'(MAX_HOUR) : item.hour_in[4:0];
        e1_next.minute  = (item.minute_in > 6'(MAX_MINUTE)) ? 6'(MAX_MINUTE) : item.minute_in;
        e1_next.second  = (item.second_in > 6'(MAX_MINUTE)) ? 6'(MAX_MINUTE) : item.second_in;
        e1_next.milli   = (item.milli_in > 10'(MAX_MILLI)) ? 10'(MAX_MILLI) : item.milli_in;
    end

    always_comb
    begin
        leap = (e1_reg.year[1:0] == 2'b00)
            && (({1'b0, e1_reg.year} != 15'(e1_reg.cent_y) * 15'(CENTURY))
                || (e1_reg.cent_y[1:0] == 2'b00));
        dim  = ((e1_reg.month == 4'(FEBRUARY)) && leap) ? 5'd29 : e1_reg.mlen;
        e2_next.ok    = (e1_reg.act == ACT_ENCODE)
            && (e1_reg.year >= 14'd1) && (e1_reg.year <= 14'(MAX_YEAR))
            && (e1_reg.month >= 4'd1) && (e1_reg.month <= 4'(MONTHS))
            && (e1_reg.day >= 5'd1) && (e1_reg.day <= dim);
        e2_next.doy   = e1_reg.cum + 9'(e1_reg.day)
            + 9'((leap && (e1_reg.month > 4'(FEBRUARY))) ? 1 : 0);
        e2_next.yterm = 23'(e1_reg.yb) * 23'(YEAR_DAYS) + 23'(e1_reg.yb >> 2);
        e2_next.cterm = e1_reg.cent_yb - (e1_reg.cent_yb >> 2);
        e2_next.ph    = 27'(e1_reg.hour) * 27'(MS_PER_HOUR);
        e2_next.pm    = 27'(e1_reg.minute) * 27'(MS_PER_MIN);
        e2_next.ps    = 27'(e1_reg.second) * 27'(MS_PER_SEC);
        e2_next.milli = e1_reg.milli;
    end

    always_comb
    begin
        days = 25'(e2_reg.yterm) + 25'(e2_reg.doy) - 25'(e2_reg.cterm) - 25'(DAY_BASE);
        tms  = e2_reg.ph + e2_reg.pm + e2_reg.ps + 27'(e2_reg.milli);
        line_next.ok         = e2_reg.ok;
        line_next.serial_day = e2_reg.ok ? 23'(days) : '0;
        line_next.day_ms     = e2_reg.ok ? tms : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg      <= e1_next;
            e2_reg      <= e2_next;
            line_reg[0] <= line_next;
            for (int i = 1; i < ENC_LINE; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign res = line_reg[ENC_LINE-1];

endmodule

`default_nettype wire

### rtl/core/sdtc_dec.sv
// ----------------------------------------------------------------------------
// sdtc_dec
// serial day and milliseconds to calendar date and time, eight stages
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_dec (
    input  logic               clk,
    input  logic               en,
    input  sdtc_pkg::in_item_t item,
    output sdtc_pkg::dec_res_t res
);
    import sdtc_pkg::*;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] milli;
    } tod_t;

    typedef struct packed {
        logic        ok;
        logic [23:0] j;
        logic [26:0] tms;
    } d1_t;

    typedef struct packed {
        logic        ok;
        logic [23:0] j;
        logic [6:0]  qy;
        logic [26:0] tms;
        logic [10:0] mins;
    } d2_t;

    typedef struct packed {
        logic        ok;
        logic [6:0]  qy;
        logic [15:0] ld;
        logic [10:0] mins;
        logic [15:0] rem;
    } d3_t;

    typedef struct packed {
        logic        ok;
        logic [6:0]  qy;
        logic [17:0] a;
        logic [6:0]  lj;
        logic [10:0] mins;
        logic [4:0]  hr;
        logic [15:0] rem;
        logic [5:0]  sec;
    } d4_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] qy;
        logic [6:0] lj;
        logic [8:0] ld2;
        tod_t       tod;
    } d5_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [10:0] b;
        logic [3:0]  lm;
        tod_t        tod;
    } d6_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  lm;
        logic [7:0]  rb;
        tod_t        tod;
    } d7_t;

    d1_t      d1_reg, d1_next;
    d2_t      d2_reg, d2_next;
    d3_t      d3_reg, d3_next;
    d4_t      d4_reg, d4_next;
    d5_t      d5_reg, d5_next;
    d6_t      d6_reg, d6_next;
    d7_t      d7_reg, d7_next;
    dec_res_t res_reg, res_next;

    logic [26:0] tms_sat;
    logic [23:0] nsum;
    logic [23:0] ry;
    logic [26:0] rm;
    logic [17:0] rj;
    logic [10:0] rmin;
    logic [15:0] rs;
    logic [8:0]  rb;
    logic [4:0]  fifth;

    // range check and shift to a march based era
    always_comb
    begin
        tms_sat = (item.day_ms_in > 27'(MAX_DAY_MS)) ? 27'(MAX_DAY_MS) : item.day_ms_in;
        nsum    = 24'(item.serial_day_in) + 24'(SHIFT_BASE);
        d1_next.ok  = (item.action == ACT_DECODE)
            && !((item.serial_day_in == '0) && (tms_sat == '0))
            && (int'(item.serial_day_in) > -DAY_BASE)
            && (int'(item.serial_day_in) <= MAX_SERIAL);
        d1_next.j   = {nsum[21:0], 2'b00} - 24'd1;
        d1_next.tms = tms_sat;
    end

    always_comb
    begin
        d2_next.ok   = d1_reg.ok;
        d2_next.j    = d1_reg.j;
        d2_next.qy   = 7'((31'(d1_reg.j) * 31'(QC_MUL)) >> QC_SH);
        d2_next.tms  = d1_reg.tms;
        d2_next.mins = 11'((39'(d1_reg.tms) * 39'(MIN_MUL)) >> MIN_SH);
    end

    always_comb
    begin
        ry = d2_reg.j - 24'(25'(d2_reg.qy) * 25'(QUAD_CENT));
        rm = d2_reg.tms - 27'(27'(d2_reg.mins) * 27'(MS_PER_MIN));
        d3_next.ok   = d2_reg.ok;
        d3_next.qy   = d2_reg.qy;
        d3_next.mins = d2_reg.mins;
        if (ry >= 24'(QUAD_CENT))
        begin
            d3_next.qy = d2_reg.qy + 7'd1;
            ry         = ry - 24'(QUAD_CENT);
        end
        if (rm >= 27'(MS_PER_MIN))
        begin
            d3_next.mins = d2_reg.mins + 11'd1;
            rm           = rm - 27'(MS_PER_MIN);
        end
        d3_next.ld  = 16'(ry >> 2);
        d3_next.rem = 16'(rm);
    end

    always_comb
    begin
        d4_next.ok   = d3_reg.ok;
        d4_next.qy   = d3_reg.qy;
        d4_next.a    = {d3_reg.ld, 2'b11};
        d4_next.lj   = 7'((26'(d4_next.a) * 26'(QY_MUL)) >> QY_SH);
        d4_next.mins = d3_reg.mins;
        d4_next.hr   = 5'((17'(d3_reg.mins) * 17'(HR_MUL)) >> HR_SH);
        d4_next.rem  = d3_reg.rem;
        d4_next.sec  = 6'((23'(d3_reg.rem) * 23'(SEC_MUL)) >> SEC_SH);
    end

    always_comb
    begin
        rj   = d4_reg.a - 18'(18'(d4_reg.lj) * 18'(QUAD_YEAR));
        rmin = d4_reg.mins - 11'(11'(d4_reg.hr) * 11'(MIN_PER_HOUR));
        rs   = d4_reg.rem - 16'(16'(d4_reg.sec) * 16'(MS_PER_SEC));
        d5_next.ok         = d4_reg.ok;
        d5_next.qy         = d4_reg.qy;
        d5_next.lj         = d4_reg.lj;
        d5_next.tod.hour   = d4_reg.hr;
        d5_next.tod.second = d4_reg.sec;
        if (rj >= 18'(QUAD_YEAR))
        begin
            d5_next.lj = d4_reg.lj + 7'd1;
            rj         = rj - 18'(QUAD_YEAR);
        end
        if (rmin >= 11'(MIN_PER_HOUR))
        begin
            d5_next.tod.hour = d4_reg.hr + 5'd1;
            rmin             = rmin - 11'(MIN_PER_HOUR);
        end
        if (rs >= 16'(MS_PER_SEC))
        begin
            d5_next.tod.second = d4_reg.sec + 6'd1;
            rs                 = rs - 16'(MS_PER_SEC);
        end
        d5_next.ld2        = 9'(rj >> 2) + 9'd1;
        d5_next.tod.minute = 6'(rmin);
        d5_next.tod.milli  = 10'(rs);
    end

    always_comb
    begin
        d6_next.ok   = d5_reg.ok;
        d6_next.year = 14'(d5_reg.qy) * 14'(CENTURY) + 14'(d5_reg.lj);
        d6_next.b    = 11'(d5_reg.ld2) * 11'(5) - 11'd3;
        d6_next.lm   = 4'((15'(d6_next.b) * 15'(FM_MUL)) >> FM_SH);
        d6_next.tod  = d5_reg.tod;
    end

    always_comb
    begin
        rb = 9'(d6_reg.b - 11'(11'(d6_reg.lm) * 11'(FIVE_MONTH)));
        d7_next.ok   = d6_reg.ok;
        d7_next.year = d6_reg.year;
        d7_next.lm   = d6_reg.lm;
        d7_next.tod  = d6_reg.tod;
        if (rb >= 9'(FIVE_MONTH))
        begin
            d7_next.lm = d6_reg.lm + 4'd1;
            rb         = rb - 9'(FIVE_MONTH);
        end
        d7_next.rb = 8'(rb);
    end

    // back from march based months, zero when not decoded
    always_comb
    begin
        fifth = 5'((16'(d7_reg.rb) * 16'(FIVE_MUL)) >> FIVE_SH) + 5'd1;
        res_next.ok     = d7_reg.ok;
        res_next.day    = fifth;
        res_next.hour   = d7_reg.tod.hour;
        res_next.minute = d7_reg.tod.minute;
        res_next.second = d7_reg.tod.second;
        res_next.milli  = d7_reg.tod.milli;
        if (d7_reg.lm < 4'(MONTH_WRAP))
        begin
            res_next.month = d7_reg.lm + 4'(MARCH_SHIFT);
            res_next.year  = d7_reg.year;
        end
        else
        begin
            res_next.month = d7_reg.lm - 4'(JAN_SHIFT);
            res_next.year  = d7_reg.year + 14'd1;
        end
        if (!d7_reg.ok)
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
            d3_reg  <= d3_next;
            d4_reg  <= d4_next;
            d5_reg  <= d5_next;
            d6_reg  <= d6_next;
            d7_reg  <= d7_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### rtl/core/serial_date_time_converter.sv
// ----------------------------------------------------------------------------
// serial_date_time_converter
// pipeline: an accepted word passes through every register stage to its result word
// throughput: one word per cycle, every stage takes a new word each cycle unless the output stalls
// a stalled output freezes every stage, nothing is dropped or repeated
// reset: asynchronous, clears the stage valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module serial_date_time_converter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // year_in, month_in, day_in, hour_in, minute_in, second_in, milli_in,
    // serial_day_in, day_ms_in, zero pad
    input  logic [sdtc_pkg::DATA_W-1:0] s_axis_tdata,
    // action
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // serial_day_out, day_ms_out, year_out, month_out, day_out, hour_out,
    // minute_out, second_out, milli_out, zero pad
    output logic [sdtc_pkg::DATA_W-1:0] m_axis_tdata,
    // valid_res
    output logic                        m_axis_tuser
);
    import sdtc_pkg::*;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    in_item_t              item;
    enc_res_t              enc_res;
    dec_res_t              dec_res;

    always_comb
    begin
        item.action        = s_axis_tuser;
        item.year_in       = s_axis_tdata[13:0];
        item.month_in      = s_axis_tdata[17:14];
        item.day_in        = s_axis_tdata[22:18];
        item.hour_in       = s_axis_tdata[28:23];
        item.minute_in     = s_axis_tdata[34:29];
        item.second_in     = s_axis_tdata[40:35];
        item.milli_in      = s_axis_tdata[50:41];
        item.serial_day_in = s_axis_tdata[73:51];
        item.day_ms_in     = s_axis_tdata[100:74];
    end

    assign en       = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign vld_next = en ? {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    sdtc_enc u_enc (
        .clk  (clk),
        .en   (en),
        .item (item),
        .res  (enc_res)
    );

    sdtc_dec u_dec (
        .clk  (clk),
        .en   (en),
        .item (item),
        .res  (dec_res)
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_axis_tuser  = enc_res.ok || dec_res.ok;
    assign m_axis_tdata  = {4'b0000, dec_res.milli, dec_res.second, dec_res.minute,
                            dec_res.hour, dec_res.day, dec_res.month, dec_res.year,
                            enc_res.day_ms, enc_res.serial_day};

`include "serial_date_time_converter_macros.svh"

    `SDTC_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0])
    `SDTC_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_reg))
    `SDTC_ASSERT_IMPL(a_tod_range, m_axis_tvalid,
                      (m_axis_tdata[77:73] <= 5'd23) && (m_axis_tdata[83:78] <= 6'd59)
                      && (m_axis_tdata[89:84] <= 6'd59) && (m_axis_tdata[99:90] <= 10'd999))
    `SDTC_ASSERT_IMPL(a_mode_exclusive, m_axis_tvalid && (m_axis_tdata[49:23] != '0),
                      m_axis_tdata[99:50] == '0)

endmodule

`default_nettype wire
